### sv/assert_macros.svh
// Assertion macros shared by the distance transform RTL.
// Depends on nothing; included by files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every cycle outside reset.
`define CHK_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("%m");
// Next-cycle implication outside reset.
`define CHK_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("%m");
`endif

### sv/lsdt_pkg.sv
// Package for the line squared distance transform: payload types, codes.
// Depends on nothing.
package lsdt_pkg;
  localparam logic [31:0] COST_INF = 32'hFFFF_FFFF;
  localparam int BW = 48;

  typedef struct packed {
    logic [31:0] cost;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] distance;
    logic [5:0]  nearest_index;
    logic        end_of_line;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RDV, S_RDV2, S_RDC, S_DIV, S_CMP, S_PUSH,
    S_EM_RD, S_EM_RD2, S_EM_CHK, S_EM_OUT
  } bk_state_t;
endpackage

### sv/lsdt_ram.sv
// Generic single-write, single-read RAM with registered read.
// Depends on nothing.
module lsdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### sv/lsdt_div.sv
// Signed 64/unsigned 16 divider, one quotient bit a cycle, floor rounding.
// Depends on nothing.
module lsdt_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic signed [63:0] num,
  input  logic [15:0]        den,
  output logic               done,
  output logic signed [63:0] quo
);
  logic [63:0] mag;
  logic [16:0] rem;
  logic [15:0] d;
  logic        neg;
  logic [6:0]  cnt;
  logic        busy;
  logic [16:0] trial;
  logic [63:0] qpos;

  assign trial = {rem[15:0], mag[63]};
  assign qpos = mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= 7'd0;
        neg  <= num[63];
        mag  <= num[63] ? 64'(-num) : num;
        rem  <= '0;
        d    <= den;
      end else if (busy) begin
        if (trial >= {1'b0, d}) begin
          rem <= trial - {1'b0, d};
          mag <= {mag[62:0], 1'b1};
        end else begin
          rem <= trial;
          mag <= {mag[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Floor: negative with remainder rounds one further down.
  always_comb begin
    if (neg) quo = (rem != '0) ? -$signed(qpos) - 64'sd1 : -$signed(qpos);
    else quo = $signed(qpos);
  end
endmodule

### sv/lsdt_front.sv
// Front part: accepts samples, tags position, queues them for the back part.
// Depends on lsdt_pkg and assert_macros.svh.
`include "assert_macros.svh"
module lsdt_front #(
  parameter int LINE_LEN = 64,
  parameter int QW = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  lsdt_pkg::in_item_t   in_item,
  output logic                 busy,
  output logic                 q_valid,
  output logic [QW-1:0]        q_pos,
  output logic [31:0]          q_cost,
  output logic                 q_fin,
  input  logic                 q_pop
);
  import lsdt_pkg::*;
  localparam int DEPTH = 2;
  logic [QW-1:0] count;
  logic [QW-1:0] pos_q [DEPTH];
  logic [31:0]   cost_q [DEPTH];
  logic          fin_q [DEPTH];
  logic          wp, rp;
  logic [1:0]    fill;
  logic          lock;
  logic          acc, fin;

  assign busy = (fill == 2'd2) || lock;
  assign acc = start && !busy;
  assign fin = in_item.last || (count == QW'(LINE_LEN - 1));
  assign q_valid = fill != 2'd0;
  assign q_pos = pos_q[rp];
  assign q_cost = cost_q[rp];
  assign q_fin = fin_q[rp];

  always_ff @(posedge clk) begin
    if (acc) begin
      pos_q[wp] <= count;
      cost_q[wp] <= in_item.cost;
      fin_q[wp] <= fin;
    end
  end

  // Lock after a last item until the back part has taken it from the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      wp <= 1'b0;
      rp <= 1'b0;
      fill <= 2'd0;
      lock <= 1'b0;
    end else begin
      if (acc) begin
        wp <= !wp;
        count <= fin ? '0 : count + QW'(1);
      end
      if (q_pop) rp <= !rp;
      fill <= fill + 2'(acc) - 2'(q_pop);
      if (acc && fin) lock <= 1'b1;
      else if (q_pop && q_fin) lock <= 1'b0;
    end
  end

  `CHK_IMPL(a_no_overflow, clk, rst, fill == 2'd2, !acc)
endmodule

### sv/lsdt_back.sv
// Back part: envelope build with a serial divider, then the emit pass.
// Depends on lsdt_pkg, lsdt_ram, lsdt_div and assert_macros.svh.
`include "assert_macros.svh"
module lsdt_back #(
  parameter int LINE_LEN = 64,
  parameter int FRAC_BITS = 8,
  parameter int QW = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  logic [QW-1:0]       q_pos,
  input  logic [31:0]         q_cost,
  input  logic                q_fin,
  output logic                q_pop,
  output logic                strobe,
  output lsdt_pkg::out_item_t result
);
  import lsdt_pkg::*;
  localparam int AW = $clog2(LINE_LEN);
  localparam int BAW = $clog2(LINE_LEN + 1);
  localparam logic signed [BW-1:0] BMAX = {1'b0, {(BW-1){1'b1}}};
  localparam logic signed [BW-1:0] BMIN = {1'b1, {(BW-1){1'b0}}};

  bk_state_t state, state_next;
  logic [QW-1:0] qc, vcur, top, p;
  logic [31:0]   cq, cv;
  logic          fin;
  logic signed [BW-1:0] s, bk;

  logic          c_we, v_we, b_we;
  logic [AW-1:0] c_ra, v_ra, v_wa, c_wa;
  logic [BAW-1:0] b_ra, b_wa;
  logic [31:0]   c_rd;
  logic [QW-1:0] v_rd, v_wd;
  logic [BW-1:0] b_rd;

  logic          div_go, div_done;
  logic signed [63:0] div_num, div_quo;
  logic [15:0]   div_den;
  logic signed [63:0] hq, hv;

  lsdt_ram #(.WIDTH(32), .DEPTH(LINE_LEN)) u_cost (
    .clk, .we(c_we), .waddr(c_wa), .wdata(q_cost), .raddr(c_ra), .rdata(c_rd));
  lsdt_ram #(.WIDTH(QW), .DEPTH(LINE_LEN)) u_vert (
    .clk, .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(v_rd));
  lsdt_ram #(.WIDTH(BW), .DEPTH(LINE_LEN + 1)) u_bnd (
    .clk, .we(b_we), .waddr(b_wa), .wdata(s), .raddr(b_ra), .rdata(b_rd));
  lsdt_div u_div (.clk, .rst, .go(div_go), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo));

  assign hq = $signed({32'd0, cq}) + $signed(64'(qc) * 64'(qc));
  assign hv = $signed({32'd0, cv}) + $signed(64'(vcur) * 64'(vcur));
  assign div_num = (hq - hv) <<< FRAC_BITS;
  assign div_den = 16'((qc - vcur) << 1);

  // Vertex memory stores the wide index; addresses map to the RAM address width.
  assign c_wa = AW'(q_pos);
  assign v_wa = (state == S_IDLE) ? AW'(0) : AW'(top + QW'(1));
  assign v_wd = (state == S_IDLE) ? '0 : qc;
  assign b_wa = BAW'(top + QW'(1));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (q_valid) state_next = (q_pos == '0) ?
                  (q_fin ? S_EM_RD : S_IDLE) : S_RDV;
      S_RDV:    state_next = S_RDV2;
      S_RDV2:   state_next = S_RDC;
      S_RDC:    state_next = S_DIV;
      S_DIV:    if (div_done) state_next = S_CMP;
      S_CMP:    state_next = (top != '0 && s <= bk) ? S_RDV : S_PUSH;
      S_PUSH:   state_next = fin ? S_EM_RD : S_IDLE;
      S_EM_RD:  state_next = S_EM_RD2;
      S_EM_RD2: state_next = S_EM_CHK;
      S_EM_CHK: state_next = (vcur < top && $signed(b_rd) <
                  $signed(BW'(p) <<< FRAC_BITS)) ? S_EM_RD : S_EM_OUT;
      S_EM_OUT: state_next = (p == qc) ? S_IDLE : S_EM_RD;
      default:  state_next = S_IDLE;
    endcase
  end

  logic div_started;
  always_comb begin
    q_pop = (state == S_IDLE) && q_valid;
    c_we = q_pop;
    v_we = (q_pop && q_pos == '0) || state == S_PUSH;
    b_we = state == S_PUSH;
    div_go = state == S_DIV && !div_started;
    c_ra = AW'(v_rd);
    v_ra = AW'(top);
    b_ra = BAW'(top);
    if (state == S_EM_RD || state == S_EM_RD2 || state == S_EM_CHK ||
        state == S_EM_OUT) begin
      v_ra = AW'(vcur);
      b_ra = BAW'(vcur + QW'(1));
    end
  end

  // vcur doubles as emit envelope index; emitted vertex kept in ev.
  logic [QW-1:0] ev;
  logic [QW:0]   dq;
  logic [63:0]   sq;
  assign dq = (p >= ev) ? {1'b0, p - ev} : {1'b0, ev - p};
  assign sq = 64'(dq) * 64'(dq) + 64'(cv);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      strobe <= 1'b0;
      div_started <= 1'b0;
      top <= '0;
    end else begin
      state <= state_next;
      strobe <= 1'b0;
      div_started <= (state == S_DIV) && !div_done;
      unique case (state)
        S_IDLE: if (q_valid) begin
          qc <= q_pos; cq <= q_cost; fin <= q_fin;
          if (q_pos == '0) begin
            top <= '0; vcur <= '0; p <= '0;
          end
        end
        S_RDV2: begin vcur <= v_rd; bk <= $signed(b_rd); end
        S_RDC: cv <= c_rd;
        S_DIV: if (div_done) begin
          if (div_quo > 64'(BMAX)) s <= BMAX;
          else if (div_quo < 64'(BMIN)) s <= BMIN;
          else s <= BW'(div_quo);
        end
        S_CMP: if (top != '0 && s <= bk) top <= top - QW'(1);
        S_PUSH: begin
          top <= top + QW'(1);
          vcur <= '0; p <= '0;
        end
        S_EM_RD: ;
        S_EM_RD2: ev <= v_rd;
        S_EM_CHK: begin
          cv <= c_rd;
          if (state_next == S_EM_RD) vcur <= vcur + QW'(1);
        end
        S_EM_OUT: begin
          strobe <= 1'b1;
          result.distance <= (cv == COST_INF || sq >= 64'(COST_INF)) ?
                             COST_INF : sq[31:0];
          result.nearest_index <= 6'(ev);
          result.end_of_line <= p == qc;
          p <= p + QW'(1);
          if (p == qc) top <= '0;
        end
        default: ;
      endcase
    end
  end

  `CHK_NEXT(a_one_strobe, clk, rst, strobe, !strobe)
  `CHK_IMPL(a_pop_idle, clk, rst, q_pop, state == S_IDLE)
endmodule

### sv/line_squared_distance_transform_unit.sv
// Line squared distance transform: lower envelope of parabolas per line.
// Per sample: queued, taken, then one crossing plus one per envelope pop (64-step serial
// divider), then a push; next sample then starts. After the last sample, each position is
// emitted after reading and checking the envelope, which advances as needed.
// Results are strobed one cycle each; the receiver cannot stall.
// Synchronous active-high reset clears counters, queue and state; stores need no clear.
module line_squared_distance_transform_unit #(
  parameter int LINE_LEN = 64,
  parameter int FRAC_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  lsdt_pkg::in_item_t  in_item,
  output logic                strobe,
  output lsdt_pkg::out_item_t result
);
  import lsdt_pkg::*;
  // Position width covers the line length.
  localparam int QW = $clog2(LINE_LEN + 1) + 1;

  logic          q_valid, q_fin, q_pop;
  logic [QW-1:0] q_pos;
  logic [31:0]   q_cost;

  // Front: take samples, tag positions, hold them in a two-entry queue.
  lsdt_front #(.LINE_LEN(LINE_LEN), .QW(QW)) u_front (
    .clk, .rst, .start, .in_item, .busy,
    .q_valid, .q_pos, .q_cost, .q_fin, .q_pop);

  // Back: envelope build and emit pass.
  lsdt_back #(.LINE_LEN(LINE_LEN), .FRAC_BITS(FRAC_BITS), .QW(QW)) u_back (
    .clk, .rst, .q_valid, .q_pos, .q_cost, .q_fin, .q_pop,
    .strobe, .result);
endmodule
